>>> sv/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Item types, controller command and status types and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        final_word;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_digest;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } sha_state_t;

  typedef enum logic [1:0] {
    PUT_INPUT,
    PUT_ZERO,
    PUT_LEN_HI,
    PUT_LEN_LO
  } sha_put_t;

  typedef struct packed {
    logic     put;
    sha_put_t put_sel;
    logic     pend_marker;
    logic     round_start;
    logic     round_step;
    logic     fold;
    logic     emit_load;
    logic     emit_shift;
    logic     reset_hash;
  } sha_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic [3:0] word_position;
    logic       round_last;
    logic       marker_pending;
  } sha_stat_t;

  localparam logic [31:0] MarkerWord = 32'h8000_0000;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> sv/sha_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer as a 16-word schedule window, round registers, hash state,
// bit length and digest output shifter.
// ----------------------------------------------------------------------------
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sha_cmd_t  cmd,
  input  wire sha_in_t   in_item,
  output sha_stat_t      stat,
  output logic [31:0]    digest_word
);

  logic [31:0] window [16];
  logic [3:0]  word_position;
  logic [63:0] total_bit_length;
  logic [31:0] hash_state [8];
  logic [31:0] v [8];
  logic [5:0]  round;
  logic [31:0] emit [8];
  logic        marker_pending;

  logic [2:0]  count;
  logic [31:0] keep;
  logic [31:0] mark;
  logic [31:0] put_word;
  logic [6:0]  add_bits;
  logic [31:0] s0, s1, w_new, e, a, big1, big0, choose, major, t1, t2;

  always_comb begin
    count = (!in_item.final_word || in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
    case (count)
      3'd0: begin keep = 32'h0000_0000; mark = 32'h8000_0000; end
      3'd1: begin keep = 32'hff00_0000; mark = 32'h0080_0000; end
      3'd2: begin keep = 32'hffff_0000; mark = 32'h0000_8000; end
      3'd3: begin keep = 32'hffff_ff00; mark = 32'h0000_0080; end
      default: begin keep = 32'hffff_ffff; mark = 32'h0000_0000; end
    endcase
    add_bits = {1'b0, count, 3'b000};
    case (cmd.put_sel)
      PUT_INPUT:  put_word = (in_item.message_word & keep) | mark;
      PUT_ZERO:   put_word = marker_pending ? MarkerWord : 32'h0;
      PUT_LEN_HI: put_word = total_bit_length[63:32];
      default:    put_word = total_bit_length[31:0];
    endcase

    s0 = {window[1][6:0], window[1][31:7]} ^ {window[1][17:0], window[1][31:18]}
       ^ (window[1] >> 3);
    s1 = {window[14][16:0], window[14][31:17]} ^ {window[14][18:0], window[14][31:19]}
       ^ (window[14] >> 10);
    w_new = s1 + window[9] + s0 + window[0];

    e = v[4];
    a = v[0];
    big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    choose = (e & v[5]) ^ (~e & v[6]);
    t1 = v[7] + big1 + choose + round_k(round) + window[0];
    big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    major = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
    t2 = big0 + major;
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      window[word_position] <= put_word;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i + 1];
      end
      window[15] <= w_new;
    end
    if (cmd.round_start) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hash_state[i];
      end
    end else if (cmd.round_step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (cmd.emit_load) begin
      for (int i = 0; i < 8; i++) begin
        emit[i] <= hash_state[i] + v[i];
      end
    end else if (cmd.emit_shift) begin
      for (int i = 0; i < 7; i++) begin
        emit[i] <= emit[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_state[i] <= InitHash[255 - 32 * i -: 32];
      end
      word_position    <= 4'd0;
      total_bit_length <= 64'd0;
      round            <= 6'd0;
      marker_pending   <= 1'b0;
    end else begin
      if (cmd.put) begin
        word_position <= word_position + 4'd1;
        if (cmd.put_sel == PUT_INPUT) begin
          total_bit_length <= total_bit_length + {57'd0, add_bits};
        end
        if (cmd.put_sel == PUT_ZERO) begin
          marker_pending <= 1'b0;
        end
      end
      if (cmd.pend_marker) begin
        marker_pending <= 1'b1;
      end
      if (cmd.round_start) begin
        round <= 6'd0;
      end else if (cmd.round_step) begin
        round <= round + 6'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          hash_state[i] <= hash_state[i] + v[i];
        end
      end
    end
  end

  assign stat.block_full     = (word_position == 4'd15);
  assign stat.word_position  = word_position;
  assign stat.round_last     = (round == 6'd63);
  assign stat.marker_pending = marker_pending;
  assign digest_word         = emit[0];

`ifndef SYNTH
  a_pos_zero_in_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.round_step |-> word_position == 4'd0)
    else $error("rounds running on a part-filled block");
  a_fold_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.fold |-> $past(cmd.round_step) && $past(round) == 6'd63)
    else $error("fold without a full set of rounds");
  a_no_put_in_rounds: assert property (@(posedge clk) disable iff (rst)
    !(cmd.put && cmd.round_step))
    else $error("buffer write during rounds");
`endif

endmodule
`default_nettype wire

>>> sv/sha_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha_control
  import sha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire sha_in_t   in_item,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [2:0]     out_index,
  input  wire sha_stat_t stat,
  output sha_cmd_t       cmd
);

  sha_state_t state, state_next;
  logic       padding, padding_next;
  logic [2:0] index, index_next;
  logic       take;
  logic       full_word;
  logic       emit_pending;
  logic       length_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      padding <= 1'b0;
      index   <= 3'd0;
    end else begin
      state   <= state_next;
      padding <= padding_next;
      index   <= index_next;
    end
  end

  always_comb begin
    state_next   = state;
    padding_next = padding;
    index_next   = index;
    cmd          = '0;
    cmd.put_sel  = PUT_ZERO;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    take         = 1'b0;
    full_word    = !in_item.final_word || in_item.byte_count >= 3'd4;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        take     = in_valid;
        if (take) begin
          cmd.put     = 1'b1;
          cmd.put_sel = PUT_INPUT;
          if (in_item.final_word) begin
            padding_next    = 1'b1;
            cmd.pend_marker = full_word;
          end
          if (stat.block_full) begin
            cmd.round_start = 1'b1;
            state_next      = ST_ROUND;
          end else if (in_item.final_word) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.put = 1'b1;
        if (stat.marker_pending || stat.word_position < 4'd14) begin
          cmd.put_sel = PUT_ZERO;
        end else if (stat.word_position == 4'd14) begin
          cmd.put_sel = PUT_LEN_HI;
        end else if (length_hi) begin
          cmd.put_sel  = PUT_LEN_LO;
          padding_next = 1'b0;
        end else begin
          cmd.put_sel = PUT_ZERO;
        end
        if (stat.block_full) begin
          cmd.round_start = 1'b1;
          state_next      = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (stat.round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold      = 1'b1;
        cmd.emit_load = emit_pending;
        if (padding || stat.marker_pending) begin
          state_next = ST_PAD;
        end else if (emit_pending) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_shift = 1'b1;
          index_next     = index + 3'd1;
          if (index == 3'd7) begin
            cmd.reset_hash = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_pending <= 1'b0;
    end else if (state == ST_PAD && cmd.put_sel == PUT_LEN_LO) begin
      emit_pending <= 1'b1;
    end else if (state == ST_FOLD) begin
      emit_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_hi <= 1'b0;
    end else begin
      length_hi <= (state == ST_PAD) && (cmd.put_sel == PUT_LEN_HI);
    end
  end

  assign out_index = index;

`ifndef SYNTH
  a_emit_after_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FOLD)
    else $error("digest shown without a finished block");
  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> index == 3'd0)
    else $error("digest index not back at zero");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("intake open while digest pending");
`endif

endmodule
`default_nettype wire

>>> sv/sha256_message_digest.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Hashes a word stream and returns the eight digest words.
// ----------------------------------------------------------------------------
//  channel  signals                      item
//  in       in_valid in_ready in_item    message word, byte count, final flag
//  out      out_valid out_ready out_item digest word, index, last flag
//
// A non-final word that does not complete a block is written into the buffer. A
// word that completes a block starts a compression of 64 rounds on the one
// round unit and one fold. The final word adds up to two padded blocks, then
// eight result items at one a cycle while out_ready is high. Reset is
// synchronous; input stalls hold the block in its current state.
// ----------------------------------------------------------------------------
module sha256_message_digest
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sha_in_t  in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sha_out_t      out_item
);

  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [31:0] digest_word;
  logic [2:0]  out_index;

  sha_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_item     (in_item),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign out_item.digest_word  = digest_word;
  assign out_item.digest_index = out_index;
  assign out_item.last_digest  = (out_index == 3'd7);

endmodule
`default_nettype wire
